// ===== design/c3zp_pkg.sv =====
// Shared constants and types for the streaming 3x3 zero-padded correlator.
`default_nettype none

package c3zp_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int ROW_CNT_W  = ROW_W + 1;
    localparam int CFG_W      = 11;
    localparam int SAMPLE_W   = 8;
    localparam int TAP_W      = 7;
    localparam int KSIZE      = 3;
    localparam int NUM_TAPS   = KSIZE * KSIZE;
    localparam int KERNEL_W   = NUM_TAPS * TAP_W;
    localparam int PROD_W     = SAMPLE_W + TAP_W;
    localparam int VALUE_W    = 18;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;

    localparam logic [CFG_W-1:0]    ROWS_RESET   = 11'd16;
    localparam logic [CFG_W-1:0]    COLS_RESET   = 11'd16;
    localparam logic [KERNEL_W-1:0] KERNEL_RESET = 63'h0102_0408_0020_4081;

    localparam logic CMD_SAMPLE = 1'b0;

    typedef enum logic [1:0] {
        REG_FRAME_ROWS,
        REG_FRAME_COLS,
        REG_KERNEL_TAPS
    } reg_idx_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [VALUE_W-1:0]  value_t;

    // Which borders of the 3x3 neighborhood fall outside the frame.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } mask_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        mask_t            edges;
    } meta_t;

    typedef struct packed {
        logic shift;
        logic prod_en;
        logic sum_en;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== design/c3zp_ram.sv =====
// Simple dual-port synchronous RAM with one write port and a registered read port.
`default_nettype none

module c3zp_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AddrW-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AddrW-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/c3zp_mac.sv =====
// 3x3 window, masked tap products and the final neighborhood sum register.
`default_nettype none

module c3zp_mac (
    input  wire logic                              clk,
    input  wire c3zp_pkg::mac_ctrl_t               ctrl,
    input  wire c3zp_pkg::sample_t                 column [c3zp_pkg::KSIZE],
    input  wire c3zp_pkg::mask_t                   edges,
    input  wire logic [c3zp_pkg::KERNEL_W-1:0]     taps,
    output c3zp_pkg::value_t                       value
);

    c3zp_pkg::sample_t window_reg [c3zp_pkg::NUM_TAPS];
    c3zp_pkg::prod_t   prod_reg   [c3zp_pkg::NUM_TAPS];
    c3zp_pkg::prod_t   prod_next  [c3zp_pkg::NUM_TAPS];
    c3zp_pkg::value_t  value_reg;
    c3zp_pkg::value_t  sum_next;

    // Rows of the window are oldest first; within a row the newest column is on the right.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            for (int r = 0; r < c3zp_pkg::KSIZE; r++)
            begin
                for (int c = 0; c < c3zp_pkg::KSIZE - 1; c++)
                begin
                    window_reg[r*c3zp_pkg::KSIZE + c] <= window_reg[r*c3zp_pkg::KSIZE + c + 1];
                end
                window_reg[r*c3zp_pkg::KSIZE + c3zp_pkg::KSIZE - 1] <= column[r];
            end
        end
        if (ctrl.prod_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.sum_en)
        begin
            value_reg <= sum_next;
        end
    end

    // Neighbors outside the frame contribute nothing, whatever the window holds there.
    always_comb
    begin
        logic skip;
        skip = 1'b0;
        for (int dr = 0; dr < c3zp_pkg::KSIZE; dr++)
        begin
            for (int dc = 0; dc < c3zp_pkg::KSIZE; dc++)
            begin
                skip = (dr == 0 && edges.top) || (dr == c3zp_pkg::KSIZE - 1 && edges.bottom)
                    || (dc == 0 && edges.left) || (dc == c3zp_pkg::KSIZE - 1 && edges.right);
                if (skip)
                begin
                    prod_next[dr*c3zp_pkg::KSIZE + dc] = '0;
                end
                else
                begin
                    prod_next[dr*c3zp_pkg::KSIZE + dc] =
                        c3zp_pkg::PROD_W'(window_reg[dr*c3zp_pkg::KSIZE + dc])
                        * c3zp_pkg::PROD_W'($signed(
                            taps[(dr*c3zp_pkg::KSIZE + dc)*c3zp_pkg::TAP_W +: c3zp_pkg::TAP_W]));
                end
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int n = 0; n < c3zp_pkg::NUM_TAPS; n++)
        begin
            sum_next = sum_next + c3zp_pkg::VALUE_W'(prod_reg[n]);
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== design/conv3x3_zero_pad_stream.sv =====
// Top level of the streaming 3x3 zero-padded correlator with its register port.
`default_nettype none

// Takes one word per clock while in_stall is low and returns at most one result word per
// clock. Samples arrive in row-major order; the result for element q is produced by the
// word at frame position q+frame_cols+1, so frame_cols+1 flush words after the last sample
// drain the frame; after that word is accepted its result passes through s1, s2, s3 and the
// output register. The rate is set by the line buffer RAM, read once and written once per
// word; when an entry is read in the same cycle that it is written, the new contents are
// forwarded. There is no clearing pass after reset or a register write: line buffer entries
// that have not been written in the current frame only feed taps that the zero padding cuts
// off. Registers sit at byte addresses 0 (frame_rows), 8 (frame_cols) and 16 (kernel_taps),
// 64 bits wide; a write restarts the frame and must only happen while the block is idle.
module conv3x3_zero_pad_stream (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 cmd,
    input  wire c3zp_pkg::sample_t                    sample,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output c3zp_pkg::value_t                          value,
    output logic [c3zp_pkg::ROW_W-1:0]                out_row,
    output logic [c3zp_pkg::COL_W-1:0]                out_col,
    output logic                                      last,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [c3zp_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [c3zp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [c3zp_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready
);

    localparam int RamW = 2 * c3zp_pkg::SAMPLE_W;

    // Configuration
    logic [c3zp_pkg::CFG_W-1:0]    rows_reg;
    logic [c3zp_pkg::CFG_W-1:0]    cols_reg;
    logic [c3zp_pkg::KERNEL_W-1:0] kernel_reg;
    logic [c3zp_pkg::CFG_W-1:0]    rows_eff;
    logic [c3zp_pkg::CFG_W-1:0]    cols_eff;
    logic [c3zp_pkg::ROW_W-1:0]    rows_m1;
    logic [c3zp_pkg::COL_W-1:0]    cols_m1;
    c3zp_pkg::reg_idx_t            cfg_idx;
    logic                          cfg_wr;
    logic                          cfg_clear;

    // Frame position counters
    logic [c3zp_pkg::ROW_CNT_W-1:0] in_row_reg, in_row_next;
    logic [c3zp_pkg::COL_W-1:0]     in_col_reg, in_col_next;
    logic [c3zp_pkg::ROW_W-1:0]     out_row_reg, out_row_next;
    logic [c3zp_pkg::COL_W-1:0]     out_col_reg, out_col_next;
    logic                           in_acc;
    logic                           started;
    logic                           in_wrap;
    logic                           out_wrap;
    logic                           out_last;
    c3zp_pkg::sample_t              x_in;
    c3zp_pkg::meta_t                meta_in;

    // Pipeline
    logic                       s1_v_reg, s1_res_reg;
    c3zp_pkg::sample_t          s1_x_reg;
    logic [c3zp_pkg::COL_W-1:0] s1_addr_reg;
    c3zp_pkg::meta_t            s1_meta_reg;
    logic                       s2_v_reg, s2_res_reg;
    c3zp_pkg::meta_t            s2_meta_reg;
    logic                       s3_v_reg;
    c3zp_pkg::meta_t            s3_meta_reg;
    logic                       out_valid_reg;
    logic [c3zp_pkg::ROW_W-1:0] out_row_reg_o;
    logic [c3zp_pkg::COL_W-1:0] out_col_reg_o;
    logic                       last_reg;
    logic                       rdy_o, rdy3, rdy2, rdy1;
    logic                       s1_move, s2_move, s3_move;

    // Line buffer: each entry holds {line above, line two above} for one column.
    logic              ram_we;
    logic [RamW-1:0]   ram_wdata;
    logic [RamW-1:0]   ram_rdata;
    logic [RamW-1:0]   rd_eff;
    logic              fwd_reg;
    logic [RamW-1:0]   fwd_data_reg;
    c3zp_pkg::sample_t above_eff;
    c3zp_pkg::sample_t two_above_eff;
    c3zp_pkg::sample_t column [c3zp_pkg::KSIZE];
    c3zp_pkg::mac_ctrl_t mac_ctrl;

    // ---------------------------------------------------------------- register port
    assign pready  = 1'b1;
    assign cfg_idx = c3zp_pkg::reg_idx_t'(paddr[c3zp_pkg::APB_ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_clear = cfg_wr && (cfg_idx == c3zp_pkg::REG_FRAME_ROWS
                                  || cfg_idx == c3zp_pkg::REG_FRAME_COLS
                                  || cfg_idx == c3zp_pkg::REG_KERNEL_TAPS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= c3zp_pkg::ROWS_RESET;
            cols_reg   <= c3zp_pkg::COLS_RESET;
            kernel_reg <= c3zp_pkg::KERNEL_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                c3zp_pkg::REG_FRAME_ROWS:  rows_reg   <= pwdata[c3zp_pkg::CFG_W-1:0];
                c3zp_pkg::REG_FRAME_COLS:  cols_reg   <= pwdata[c3zp_pkg::CFG_W-1:0];
                c3zp_pkg::REG_KERNEL_TAPS: kernel_reg <= pwdata[c3zp_pkg::KERNEL_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            c3zp_pkg::REG_FRAME_ROWS:  prdata = c3zp_pkg::APB_DATA_W'(rows_reg);
            c3zp_pkg::REG_FRAME_COLS:  prdata = c3zp_pkg::APB_DATA_W'(cols_reg);
            c3zp_pkg::REG_KERNEL_TAPS: prdata = c3zp_pkg::APB_DATA_W'(kernel_reg);
            default:                   prdata = '0;
        endcase
    end

    // A size of zero acts as one, and sizes beyond the buffers saturate.
    always_comb
    begin
        if (rows_reg == '0)
            rows_eff = c3zp_pkg::CFG_W'(1);
        else if (rows_reg > c3zp_pkg::CFG_W'(c3zp_pkg::MAX_ROWS))
            rows_eff = c3zp_pkg::CFG_W'(c3zp_pkg::MAX_ROWS);
        else
            rows_eff = rows_reg;

        if (cols_reg == '0)
            cols_eff = c3zp_pkg::CFG_W'(1);
        else if (cols_reg > c3zp_pkg::CFG_W'(c3zp_pkg::MAX_COLS))
            cols_eff = c3zp_pkg::CFG_W'(c3zp_pkg::MAX_COLS);
        else
            cols_eff = cols_reg;
    end

    assign rows_m1 = c3zp_pkg::ROW_W'(rows_eff - c3zp_pkg::CFG_W'(1));
    assign cols_m1 = c3zp_pkg::COL_W'(cols_eff - c3zp_pkg::CFG_W'(1));

    // ---------------------------------------------------------------- handshake
    assign rdy_o    = !out_valid_reg || !out_stall;
    assign rdy3     = !s3_v_reg || rdy_o;
    assign rdy2     = !s2_v_reg || !s2_res_reg || rdy3;
    assign rdy1     = !s1_v_reg || rdy2;
    assign in_stall = !rdy1;
    assign in_acc   = in_valid && rdy1;
    assign s1_move  = s1_v_reg && rdy2;
    assign s2_move  = s2_v_reg && s2_res_reg && rdy3;
    assign s3_move  = s3_v_reg && rdy_o;

    // ---------------------------------------------------------------- input stage
    // Results start once the word one row and one column past the first sample arrives.
    assign started  = (in_row_reg > c3zp_pkg::ROW_CNT_W'(1))
                   || (in_row_reg == c3zp_pkg::ROW_CNT_W'(1) && in_col_reg != '0);
    assign in_wrap  = (in_col_reg == cols_m1);
    assign out_wrap = (out_col_reg == cols_m1);
    assign out_last = (out_row_reg == rows_m1) && out_wrap;
    assign x_in     = (cmd == c3zp_pkg::CMD_SAMPLE
                       && in_row_reg < c3zp_pkg::ROW_CNT_W'(rows_eff)) ? sample : '0;

    always_comb
    begin
        meta_in.row          = out_row_reg;
        meta_in.col          = out_col_reg;
        meta_in.last         = out_last;
        meta_in.edges.top    = (out_row_reg == '0);
        meta_in.edges.bottom = (out_row_reg == rows_m1);
        meta_in.edges.left   = (out_col_reg == '0);
        meta_in.edges.right  = out_wrap;
    end

    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (cfg_clear || (in_acc && started && out_last))
        begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
        else if (in_acc)
        begin
            if (in_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + c3zp_pkg::ROW_CNT_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + c3zp_pkg::COL_W'(1);
            end
            if (started)
            begin
                if (out_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + c3zp_pkg::ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + c3zp_pkg::COL_W'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            s1_v_reg      <= 1'b0;
            s1_res_reg    <= 1'b0;
            s2_v_reg      <= 1'b0;
            s2_res_reg    <= 1'b0;
            s3_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            if (rdy1)
            begin
                s1_v_reg   <= in_valid;
                s1_res_reg <= started;
            end
            if (rdy2)
            begin
                s2_v_reg   <= s1_v_reg;
                s2_res_reg <= s1_res_reg;
            end
            if (rdy3)
            begin
                s3_v_reg <= s2_v_reg && s2_res_reg;
            end
            if (rdy_o)
            begin
                out_valid_reg <= s3_v_reg;
            end
            // The read issued now misses a write to the same entry at this very edge.
            if (in_acc)
            begin
                fwd_reg <= s1_move && (s1_addr_reg == in_col_reg);
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_x_reg     <= x_in;
            s1_addr_reg  <= in_col_reg;
            s1_meta_reg  <= meta_in;
            fwd_data_reg <= ram_wdata;
        end
        if (s1_move)
        begin
            s2_meta_reg <= s1_meta_reg;
        end
        if (s2_move)
        begin
            s3_meta_reg <= s2_meta_reg;
        end
        if (s3_move)
        begin
            out_row_reg_o <= s3_meta_reg.row;
            out_col_reg_o <= s3_meta_reg.col;
            last_reg      <= s3_meta_reg.last;
        end
    end

    // ---------------------------------------------------------------- line buffer
    assign rd_eff        = fwd_reg ? fwd_data_reg : ram_rdata;
    assign above_eff     = c3zp_pkg::sample_t'(rd_eff[RamW-1:c3zp_pkg::SAMPLE_W]);
    assign two_above_eff = c3zp_pkg::sample_t'(rd_eff[c3zp_pkg::SAMPLE_W-1:0]);
    assign ram_we        = s1_move;
    assign ram_wdata     = {s1_x_reg, above_eff};

    c3zp_ram #(
        .DEPTH (c3zp_pkg::MAX_COLS),
        .WIDTH (RamW)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .re    (in_acc),
        .raddr (in_col_reg),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- window and sum
    assign column[0] = two_above_eff;
    assign column[1] = above_eff;
    assign column[2] = s1_x_reg;

    assign mac_ctrl.shift   = s1_move;
    assign mac_ctrl.prod_en = s2_move;
    assign mac_ctrl.sum_en  = s3_move;

    c3zp_mac u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .column (column),
        .edges  (s2_meta_reg.edges),
        .taps   (kernel_reg),
        .value  (value)
    );

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg_o;
    assign out_col   = out_col_reg_o;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_col_reg <= cols_m1)
        else $error("input column counter beyond the frame width");

    a_out_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_row_reg <= rows_m1 && out_col_reg <= cols_m1)
        else $error("output position beyond the frame");

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> out_row_reg_o == rows_m1 && out_col_reg_o == cols_m1)
        else $error("last word is not the bottom right element");

    a_stall_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_v_reg && s2_v_reg && s2_res_reg && s3_v_reg && out_valid_reg)
        else $error("input stalled while the pipeline has room");
`endif

endmodule

`default_nettype wire
